@@ hdl/mhr_pkg.sv @@
package mhr_pkg;

    localparam int FUNC_W  = 2;
    localparam int NODE_W  = 10;
    localparam int VAL_W   = 31;
    localparam int CFG_W   = 4;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // s_axis_tdata layout
    localparam int S_NODE_LSB = 0;
    localparam int S_WVAL_LSB = S_NODE_LSB + NODE_W;
    localparam int S_USED_W   = S_WVAL_LSB + VAL_W;

    // m_axis_tdata layout
    localparam int M_VAL_LSB  = 0;
    localparam int M_NODE_LSB = M_VAL_LSB + VAL_W;
    localparam int M_USED_W   = M_NODE_LSB + NODE_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_READ,
        S_STEP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        WR_INPUT,
        WR_CHILD,
        WR_ZERO
    } t_wr_sel;

    typedef struct packed {
        logic    capture;
        logic    rd_self;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    capture_vout;
        logic    step;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  oor;
        logic  leaf;
    } t_dp_sts;

endpackage

@@ hdl/max_heap_node_removal.sv @@
// Binary max-heap node store with write, read and remove requests.
// Slave stream: one request per transfer; tuser carries func, tdata carries
// node_index and write_value. Master stream: one result per request.
// Config channel: i_cfg_valid/o_cfg_ready/i_cfg_data write active_levels;
// write it only while no request is in flight. o_cfg_ready is always high.
// A write stores write_value at its node and a read fetches the node; a
// remove fetches the node and then moves the hole down one level per step:
// read both children from the even/odd node banks, then write the larger
// one (the right one on a tie) into the parent, until at a leaf the hole is
// zeroed. One request is in flight at a time; s_axis_tready returns in the
// cycle the result becomes valid.
// A finished result waits in the output register while the next request
// is accepted and worked on; a stalled receiver holds the block in its
// final cycle until the output register frees.
// Reset (synchronous, active low) empties the output and sets
// active_levels to 10 (or MAX_LEVELS when smaller). Heap contents are not
// cleared; nodes must be written before they are read.
module max_heap_node_removal #(
    parameter int MAX_LEVELS = 10,
    parameter int VALUE_BITS = 31
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [9:0] node_index, [40:10] write_value, rest zero
    input  logic [mhr_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] func
    input  logic [mhr_pkg::FUNC_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [30:0] value_out, [40:31] emptied_node, rest zero
    output logic [mhr_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] status
    output logic                              m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mhr_pkg::CFG_W-1:0]         i_cfg_data
);
    import mhr_pkg::*;

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [VAL_W-1:0]  out_value;
    logic [NODE_W-1:0] out_node;
    logic              out_status;

    assign o_cfg_ready = 1'b1;

    mhr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mhr_dp #(.MAX_LEVELS(MAX_LEVELS), .VALUE_BITS(VALUE_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_func     (t_func'(s_axis_tuser)),
        .i_node     (s_axis_tdata[S_NODE_LSB +: NODE_W]),
        .i_wval     (s_axis_tdata[S_WVAL_LSB +: VAL_W]),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_value    (out_value),
        .o_emptied  (out_node),
        .o_status   (out_status)
    );

    assign m_axis_tdata = {{(M_TDATA_W - M_USED_W){1'b0}}, out_node, out_value};
    assign m_axis_tuser = out_status;

    // one request at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // an ignored request empties no node and returns no value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[M_NODE_LSB +: NODE_W] == '0) &&
            (m_axis_tdata[M_VAL_LSB +: VAL_W] == '0))
        else $error("out-of-range result carries data");

    // the hole only moves down past a non-empty child, writing it up
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !sts.leaf && cmd.wr_en && (cmd.wr_sel == WR_CHILD))
        else $error("sift step at a leaf");

    // the result register is loaded only when the receiver can take it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !m_axis_tvalid || m_axis_tready)
        else $error("result overwritten before transfer");

endmodule

@@ hdl/mhr_ram.sv @@
module mhr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/mhr_ctrl.sv @@
module mhr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output mhr_pkg::t_dp_cmd o_cmd,
    input  mhr_pkg::t_dp_sts i_sts
);
    import mhr_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.wr_sel = WR_INPUT;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.oor) begin
                    n_state = S_DONE;
                end else begin
                    case (i_sts.func)
                        FUNC_WRITE: begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = WR_INPUT;
                            n_state = S_DONE;
                        end
                        FUNC_REMOVE, FUNC_READ: begin
                            o_cmd.rd_self = 1'b1;
                            n_state = S_FETCH;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                o_cmd.capture_vout = 1'b1;
                n_state = (i_sts.func == FUNC_REMOVE) ? S_READ : S_DONE;
            end
            S_READ: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.leaf) begin
                    o_cmd.wr_sel = WR_ZERO;
                    n_state = S_DONE;
                end else begin
                    o_cmd.wr_sel = WR_CHILD;
                    o_cmd.step   = 1'b1;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/mhr_dp.sv @@
module mhr_dp #(
    parameter int MAX_LEVELS = 10,
    parameter int VALUE_BITS = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mhr_pkg::CFG_W-1:0]    i_cfg_data,
    input  mhr_pkg::t_func               i_func,
    input  logic [mhr_pkg::NODE_W-1:0]   i_node,
    input  logic [mhr_pkg::VAL_W-1:0]    i_wval,
    input  mhr_pkg::t_dp_cmd             i_cmd,
    output mhr_pkg::t_dp_sts             o_sts,
    output logic [mhr_pkg::VAL_W-1:0]    o_value,
    output logic [mhr_pkg::NODE_W-1:0]   o_emptied,
    output logic                         o_status
);
    import mhr_pkg::*;

    localparam int AW    = MAX_LEVELS - 1;
    localparam int DEPTH = 1 << AW;
    localparam int LVW   = $clog2(MAX_LEVELS + 1);
    localparam int NXW   = MAX_LEVELS + NODE_W;
    localparam int VXW   = VALUE_BITS + VAL_W;
    localparam logic [CFG_W-1:0] LV_RST = CFG_W'((MAX_LEVELS < 10) ? MAX_LEVELS : 10);

    logic [CFG_W-1:0]      r_cfg_lv;
    t_func                 r_func;
    logic [MAX_LEVELS-1:0] r_node;
    logic [VALUE_BITS-1:0] r_wval;
    logic                  r_oor;
    logic                  r_kids_ok;
    logic [VALUE_BITS-1:0] r_vout;
    logic [VAL_W-1:0]      r_out_val;
    logic [NODE_W-1:0]     r_out_node;
    logic                  r_out_status;

    logic [LVW-1:0]        lv;
    logic                  in_oor;
    logic                  kids_ok;
    logic [NXW-1:0]        node_in_x;
    logic [NXW-1:0]        node_out_x;
    logic [VXW-1:0]        wval_x;
    logic [VXW-1:0]        vout_x;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [VALUE_BITS-1:0] even_q, odd_q;
    logic [VALUE_BITS-1:0] lc, rc, child_val;
    logic                  rc_wins;
    logic                  we_even, we_odd;

    always_comb begin
        if (r_cfg_lv == '0) begin
            lv = LVW'(1);
        end else if (int'(r_cfg_lv) > MAX_LEVELS) begin
            lv = LVW'(MAX_LEVELS);
        end else begin
            lv = LVW'(r_cfg_lv);
        end
    end

    assign node_in_x  = NXW'(i_node);
    assign node_out_x = NXW'(r_node);
    assign wval_x     = VXW'(i_wval);
    assign vout_x     = VXW'(r_vout);

    assign in_oor  = (i_node == '0) || ((i_node >> lv) != '0);
    assign kids_ok = ((r_node >> (lv - LVW'(1))) == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_lv <= LV_RST;
        end else if (i_cfg_we) begin
            r_cfg_lv <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kids_ok <= kids_ok;
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_node <= node_in_x[MAX_LEVELS-1:0];
            r_wval <= wval_x[VALUE_BITS-1:0];
            r_oor  <= in_oor;
        end else if (i_cmd.step) begin
            r_node <= {r_node[MAX_LEVELS-2:0], rc_wins};
        end
        if (i_cmd.capture_vout) begin
            r_vout <= r_node[0] ? odd_q : even_q;
        end
        if (i_cmd.load_out) begin
            r_out_val <= (!r_oor && (r_func == FUNC_READ || r_func == FUNC_REMOVE))
                         ? vout_x[VAL_W-1:0] : '0;
            r_out_node <= (!r_oor && r_func == FUNC_REMOVE) ? node_out_x[NODE_W-1:0] : '0;
            r_out_status <= r_oor && (r_func != FUNC_NOP);
        end
    end

    // children 2n and 2n+1 sit at address n of the even and odd banks
    assign raddr = i_cmd.rd_self ? r_node[MAX_LEVELS-1:1] : r_node[MAX_LEVELS-2:0];
    assign waddr = r_node[MAX_LEVELS-1:1];

    assign lc        = r_kids_ok ? even_q : '0;
    assign rc        = r_kids_ok ? odd_q  : '0;
    assign rc_wins   = !(lc > rc);
    assign child_val = rc_wins ? rc : lc;

    always_comb begin
        case (i_cmd.wr_sel)
            WR_INPUT: wdata = r_wval;
            WR_CHILD: wdata = child_val;
            default:  wdata = '0;
        endcase
    end

    assign we_even = i_cmd.wr_en && !r_node[0];
    assign we_odd  = i_cmd.wr_en && r_node[0];

    mhr_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_ram_even (
        .i_clk   (i_clk),
        .i_we    (we_even),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (even_q)
    );

    mhr_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_ram_odd (
        .i_clk   (i_clk),
        .i_we    (we_odd),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (odd_q)
    );

    assign o_sts.func = r_func;
    assign o_sts.oor  = r_oor;
    assign o_sts.leaf = (lc == '0) && (rc == '0);

    assign o_value   = r_out_val;
    assign o_emptied = r_out_node;
    assign o_status  = r_out_status;

endmodule
